// ===== hdl/grvg_pkg.sv =====
// Shared types and constants of the geometric variate generator.
package grvg_pkg;

    localparam int DATA_W    = 32;
    localparam int REG_COUNT = 4;
    localparam int CFG_IDX_W = $clog2(REG_COUNT);
    localparam int SEL_W     = 2;
    localparam int U_W       = 15;
    localparam int K_W       = 16;

    localparam logic [DATA_W-1:0] LCG_MUL = 32'd1103515245;
    localparam logic [DATA_W-1:0] LCG_ADD = 32'd12345;
    localparam logic [DATA_W-1:0] LCG_RESET_VAL = 32'd1;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Operand request to the shared multiplier
    typedef struct packed {
        logic              en;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } mul_req_t;

endpackage

// ===== hdl/grvg_mul.sv =====
// Shared 32x32 unsigned multiplier with registered 64-bit product.
module grvg_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  grvg_pkg::mul_req_t            req,
    output logic [2*grvg_pkg::DATA_W-1:0] prod
);
    import grvg_pkg::*;

    logic [2*DATA_W-1:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
        end
        else if (req.en)
        begin
            prod_reg <= {{DATA_W{1'b0}}, req.a} * {{DATA_W{1'b0}}, req.b};
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/grvg_regs.sv =====
// Ratio register file: config writes and distribution select.
module grvg_regs #(
    parameter int NUM_DIST = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [grvg_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [grvg_pkg::DATA_W-1:0]    cfg_data,
    input  logic [grvg_pkg::SEL_W-1:0]     sel,
    output logic [grvg_pkg::DATA_W-1:0]    ratio
);
    import grvg_pkg::*;

    logic [DATA_W-1:0]    ratio_reg [REG_COUNT];
    logic [CFG_IDX_W-1:0] rd_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                ratio_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            ratio_reg[cfg_addr] <= cfg_data;
        end
    end

    // selector beyond the distribution count falls back to distribution 0
    always_comb
    begin
        if (32'(sel) < NUM_DIST)
        begin
            rd_idx = CFG_IDX_W'(sel);
        end
        else
        begin
            rd_idx = '0;
        end
    end

    assign ratio = ratio_reg[rd_idx];

endmodule

// ===== hdl/geometric_random_variate_generator.sv =====
// Top level of the geometric variate generator: sequencer, LCG and output register.
//
// Draws geometric variates by fixed-point inversion. A draw beat (tuser op = 0)
// advances a 32-bit LCG (state*1103515245 + 12345), takes the 15-bit uniform
// u = state[30:16], forms pos = u mod TABLE_SIZE and returns the smallest k >= 1
// whose Q0.32 tail q^k (truncating multiplies) is at or below
// 1 - (pos + 0.5)/TABLE_SIZE; q is the ratio register picked by dist_select. If no
// k up to MAX_VALUE passes, MAX_VALUE is returned with the saturated flag set.
// A reseed beat (op = 1) loads the LCG from tdata and gives no result.
// Every product goes through one shared 32x32 multiplier. A draw steps through
// the LCG step and the modulo (ST_LCG, ST_ADV, ST_QUO, ST_REM, ST_POS), then for
// each candidate k through ST_SCALE (tail * 2*TABLE_SIZE for the threshold test),
// ST_TEST (compare, launch tail * q) and ST_STEP (take the next power of q); the
// last candidate skips ST_STEP. ST_OUT then loads the output register and returns
// the sequencer to idle. One item is in work at a time; the input is ready only
// while the sequencer is idle, and a finished result sits in the output register
// so the next beat can be taken before it is collected. A result that finds the
// output register still full waits until it is drained. The user must write the
// ratio registers through cfg_we/cfg_addr/cfg_data only while idle; the block
// itself does not enforce it.
module geometric_random_variate_generator #(
    parameter int NUM_DIST   = 4,
    parameter int TABLE_SIZE = 32768,
    parameter int MAX_VALUE  = 65535
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [grvg_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [grvg_pkg::DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // [31:0] seed_value
    input  logic [2:0]                     s_axis_tuser,  // [0] op, [2:1] dist_select
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,  // [15:0] variate
    output logic [0:0]                     m_axis_tuser   // [0] saturated
);
    import grvg_pkg::*;

    // threshold scale and reciprocal for the exact u / TABLE_SIZE
    localparam int TWO_T_W = 17;
    localparam logic [TWO_T_W-1:0] TWO_T = TWO_T_W'(2 * TABLE_SIZE);
    localparam int DIV_SH = U_W + $clog2(TABLE_SIZE);
    localparam longint RECIP_L = ((longint'(1) << DIV_SH) + longint'(TABLE_SIZE) - 1)
                                 / longint'(TABLE_SIZE);
    localparam logic [DATA_W-1:0] RECIP   = RECIP_L[DATA_W-1:0];
    localparam logic [DATA_W-1:0] T_CONST = DATA_W'(TABLE_SIZE);
    localparam logic [K_W-1:0]    K_MAX   = K_W'(MAX_VALUE);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LCG,    // state * multiplier
        ST_ADV,    // add increment, take uniform
        ST_QUO,    // u * reciprocal
        ST_REM,    // quotient * TABLE_SIZE
        ST_POS,    // remainder, threshold numerator
        ST_SCALE,  // tail * 2*TABLE_SIZE
        ST_TEST,   // compare, launch tail * q
        ST_STEP,   // take next tail
        ST_OUT     // hand over to output register
    } state_t;

    state_t              state_reg;
    logic [DATA_W-1:0]   lcg_reg;
    logic [DATA_W-1:0]   q_reg;
    logic [DATA_W-1:0]   tail_reg;
    logic [U_W-1:0]      u_reg;
    logic [K_W-1:0]      r_reg;    // 2T - 2pos - 1
    logic [K_W-1:0]      k_reg;
    logic                sat_reg;
    logic                m_valid_reg;
    logic [K_W-1:0]      out_k_reg;
    logic                out_sat_reg;

    mul_req_t            mul_req;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0]   ratio_sel;
    logic [DATA_W-1:0]   lcg_sum;
    logic [U_W-1:0]      quot;
    logic [U_W-1:0]      pos;
    logic [TWO_T_W-1:0]  r_full;
    logic                hit;
    logic                in_acc;
    logic                out_load;

    grvg_regs #(
        .NUM_DIST (NUM_DIST)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .sel      (s_axis_tuser[2:1]),
        .ratio    (ratio_sel)
    );

    grvg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .prod  (prod)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    // finished result moves into the output register when it is free or draining
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    assign lcg_sum = prod[DATA_W-1:0] + LCG_ADD;
    assign quot    = U_W'(prod >> DIV_SH);
    assign pos     = u_reg - prod[U_W-1:0];
    assign r_full  = TWO_T - {1'b0, pos, 1'b0} - TWO_T_W'(1);
    // tail * 2T <= (2T - 2pos - 1) * 2^32
    assign hit     = (prod <= {16'b0, r_reg, 32'b0});

    // operands for the shared multiplier
    always_comb
    begin
        mul_req = '0;
        case (state_reg)
            ST_LCG:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = lcg_reg;
                mul_req.b  = LCG_MUL;
            end
            ST_QUO:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = DATA_W'(u_reg);
                mul_req.b  = RECIP;
            end
            ST_REM:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = DATA_W'(quot);
                mul_req.b  = T_CONST;
            end
            ST_SCALE:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = tail_reg;
                mul_req.b  = DATA_W'(TWO_T);
            end
            ST_TEST:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = tail_reg;
                mul_req.b  = q_reg;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            lcg_reg     <= LCG_RESET_VAL;
            q_reg       <= '0;
            tail_reg    <= '0;
            u_reg       <= '0;
            r_reg       <= '0;
            k_reg       <= '0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            out_k_reg   <= '0;
            out_sat_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (s_axis_tuser[0] == OP_RESEED)
                        begin
                            lcg_reg <= s_axis_tdata;
                        end
                        else
                        begin
                            q_reg     <= ratio_sel;
                            state_reg <= ST_LCG;
                        end
                    end
                end
                ST_LCG:
                begin
                    state_reg <= ST_ADV;
                end
                ST_ADV:
                begin
                    lcg_reg   <= lcg_sum;
                    u_reg     <= lcg_sum[16 +: U_W];
                    state_reg <= ST_QUO;
                end
                ST_QUO:
                begin
                    state_reg <= ST_REM;
                end
                ST_REM:
                begin
                    state_reg <= ST_POS;
                end
                ST_POS:
                begin
                    r_reg     <= r_full[K_W-1:0];
                    tail_reg  <= q_reg;
                    k_reg     <= K_W'(1);
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_TEST;
                end
                ST_TEST:
                begin
                    if (hit)
                    begin
                        sat_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                    else if (k_reg == K_MAX)
                    begin
                        sat_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    tail_reg  <= prod[2*DATA_W-1:DATA_W];
                    k_reg     <= k_reg + K_W'(1);
                    state_reg <= ST_SCALE;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        out_k_reg   <= k_reg;
                        out_sat_reg <= sat_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = out_k_reg;
    assign m_axis_tuser[0] = out_sat_reg;

`ifndef SYNTHESIS
    // a reseed beat lands in the generator state
    a_reseed_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tuser[0] == OP_RESEED) |=> (lcg_reg == $past(s_axis_tdata)))
        else $error("reseed did not load generator state");

    // candidate index stays within 1..MAX_VALUE while searching
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST) |-> (k_reg != '0 && k_reg <= K_MAX))
        else $error("candidate k out of range");

    // the tail never grows from one power to the next
    a_tail_falls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |=> (tail_reg <= $past(tail_reg)))
        else $error("tail increased");

    // saturation only reported at the maximum value
    a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == K_MAX))
        else $error("saturated result below maximum");

    // a result is never zero
    a_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != '0))
        else $error("zero variate");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking stream testbench for the geometric random variate generator.
module testbench;
    import grvg_pkg::*;

    // Block configuration, passed to the instance so the predictor and the RTL agree
    localparam int NUM_DIST   = 4;
    localparam int TABLE_SIZE = 32768;
    localparam int MAX_VALUE  = 65535;

    // Ratio register indexes
    localparam int RATIO_0 = 0;
    localparam int RATIO_1 = 1;
    localparam int RATIO_2 = 2;
    localparam int RATIO_3 = 3;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 20;     // generous margin
    localparam int IDLE_PCT      = 32;
    localparam int CALM_LO       = 300;    // beats/results in [CALM_LO, CALM_HI): no idling
    localparam int CALM_HI       = 420;
    localparam int HOLD_AT       = 120;    // result count at which the sink backs off
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 210;
    localparam int RESEED_PCT    = 12;

    localparam logic [DATA_W-1:0] Q_ZERO = 32'h0000_0000;
    localparam logic [DATA_W-1:0] Q_HALF = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_HIGH = 32'hF000_0000;   // mean about 16
    localparam logic [DATA_W-1:0] Q_FULL = 32'hFFFF_FFFF;   // always saturates

    typedef struct packed {
        logic              op;
        logic [SEL_W-1:0]  dist_sel;
        logic [DATA_W-1:0] seed;
    } gen_req_t;

    typedef struct packed {
        logic [K_W-1:0] variate;
        logic           saturated;
    } variate_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    geometric_random_variate_generator #(
        .NUM_DIST   (NUM_DIST),
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_VALUE  (MAX_VALUE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] seed_value
        .s_axis_tuser  (s_axis_tuser),   // [0] op, [2:1] dist_select
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [15:0] variate
        .m_axis_tuser  (m_axis_tuser)    // [0] saturated
    );

    // Predictor state: its own copy of the ratios and the generator
    logic [DATA_W-1:0] ratio_copy [REG_COUNT] = '{default: '0};
    logic [DATA_W-1:0] lcg_copy = LCG_RESET_VAL;

    gen_req_t req_q [$];            // beats waiting for the source
    variate_t expected_variates [$];

    int reqs_queued = 0;
    int beats_in    = 0;
    int results_in  = 0;
    int draws       = 0;
    int reseeds     = 0;
    int saturations = 0;
    int settings    = 0;
    int mismatches  = 0;
    int cycle_count = 0;

    logic in_taken = 1'b0;         // input beat accepted at the last rising edge
    int   hold_left = 0;
    logic hold_done = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Inversion search: smallest k whose truncated Q0.32 power of q is at or
    // below 1 - (pos + 0.5)/TABLE_SIZE, compared exactly in integers.
    function automatic variate_t geometric_search(input logic [DATA_W-1:0] q,
                                                  input logic [U_W-1:0] pos);
        longint unsigned span;
        longint unsigned bound;
        longint unsigned tail;
        variate_t        res;
        span  = 64'(2 * TABLE_SIZE);
        bound = (span - 2 * 64'(pos) - 1) << 32;
        tail  = 64'(q);
        res.variate   = K_W'(MAX_VALUE);
        res.saturated = 1'b1;
        for (int cand = 1; cand <= MAX_VALUE; cand++)
        begin
            if (tail * span <= bound)
            begin
                res.variate   = K_W'(cand);
                res.saturated = 1'b0;
                return res;
            end
            tail = (tail * 64'(q)) >> 32;
        end
        return res;
    endfunction

    // Seed whose next LCG step lands on the given state (modular inverse by Newton)
    function automatic logic [DATA_W-1:0] seed_leading_to(input logic [DATA_W-1:0] target);
        logic [DATA_W-1:0] inv;
        inv = LCG_MUL;
        repeat (5) inv = inv * (32'd2 - LCG_MUL * inv);
        return (target - LCG_ADD) * inv;
    endfunction

    function automatic logic [DATA_W-1:0] pick_ratio();
        case ($urandom_range(3))
            0:       return Q_ZERO;
            1:       return Q_HIGH;
            2:       return $urandom_range(Q_HIGH);
            default: return $urandom_range(Q_HALF);
        endcase
    endfunction

    task automatic queue_req(input logic op, input logic [SEL_W-1:0] dist_sel,
                             input logic [DATA_W-1:0] seed);
        gen_req_t req;
        req.op       = op;
        req.dist_sel = dist_sel;
        req.seed     = seed;
        req_q.push_back(req);
        reqs_queued++;
    endtask

    task automatic write_ratio(input int idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_IDX_W'(idx);
        cfg_data <= val;
        ratio_copy[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Every queued beat taken and every draw answered, then a short settle
    task automatic wait_idle();
        while (beats_in != reqs_queued || expected_variates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Source: one offer per falling edge, held until taken
    always @(negedge clk)
    begin
        gen_req_t req;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (req_q.size() != 0 &&
                ((beats_in >= CALM_LO && beats_in < CALM_HI) ||
                 $urandom_range(99) >= IDLE_PCT))
            begin
                req = req_q.pop_front();
                s_axis_tdata  <= req.seed;
                s_axis_tuser  <= {req.dist_sel, req.op};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Sink: random back-pressure plus one long hold-off so the block backs up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_left - 1;
            end
            else if (results_in == HOLD_AT && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                hold_left     <= HOLD_CYCLES;
                hold_done     <= 1'b1;
            end
            else
                m_axis_tready <= (results_in >= CALM_LO && results_in < CALM_HI) ||
                                 $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Monitor: predict on input beats, check output beats in order
    always @(posedge clk)
    begin
        logic [U_W-1:0]   uni;
        logic [SEL_W-1:0] sel;
        variate_t         want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                beats_in++;
                if (s_axis_tuser[0] == OP_RESEED)
                begin
                    lcg_copy = s_axis_tdata;
                    reseeds++;
                end
                else
                begin
                    sel = s_axis_tuser[2:1];
                    if (sel >= NUM_DIST)
                        sel = '0;
                    lcg_copy = lcg_copy * LCG_MUL + LCG_ADD;
                    uni  = lcg_copy[30:16];
                    want = geometric_search(ratio_copy[sel], U_W'(uni % TABLE_SIZE));
                    expected_variates.push_back(want);
                    draws++;
                    if (want.saturated)
                        saturations++;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_in++;
                if (expected_variates.size() == 0)
                begin
                    $display("%0t: unexpected result beat, variate %0d saturated %0d",
                             $time, m_axis_tdata, m_axis_tuser[0]);
                    mismatches++;
                end
                else
                begin
                    want = expected_variates.pop_front();
                    if (m_axis_tdata !== want.variate)
                    begin
                        $display("%0t: variate expected %0d, got %0d",
                                 $time, want.variate, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tuser[0] !== want.saturated)
                    begin
                        $display("%0t: saturated expected %0d, got %0d",
                                 $time, want.saturated, m_axis_tuser[0]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_variates.size());
            $display("geometric_random_variate_generator: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero ratio, half, high, and the saturating ratio
        write_ratio(RATIO_0, Q_ZERO);
        write_ratio(RATIO_1, Q_HALF);
        write_ratio(RATIO_2, 32'hE000_0000);
        write_ratio(RATIO_3, Q_FULL);
        settings++;

        queue_req(OP_DRAW, 2'd0, 32'h0000_0000);   // first draw from the reset state
        queue_req(OP_DRAW, 2'd1, 32'hFFFF_FFFF);   // seed field ignored on a draw
        queue_req(OP_DRAW, 2'd2, 32'hA5A5_5A5A);
        queue_req(OP_DRAW, 2'd3, 32'h0000_0001);   // no k qualifies: saturates
        // table position zero (largest threshold)
        queue_req(OP_RESEED, 2'd3, seed_leading_to(32'h0000_0000));
        queue_req(OP_DRAW, 2'd1, 32'h0);
        // last table position (smallest threshold)
        queue_req(OP_RESEED, 2'd0, seed_leading_to(32'h7FFF_0000));
        queue_req(OP_DRAW, 2'd1, 32'h0);
        queue_req(OP_RESEED, 2'd2, seed_leading_to(32'h7FFF_0000));
        queue_req(OP_DRAW, 2'd2, 32'h0);
        queue_req(OP_RESEED, 2'd1, seed_leading_to(32'h7FFF_0000));
        queue_req(OP_DRAW, 2'd0, 32'h0);           // zero ratio still gives one
        queue_req(OP_RESEED, 2'd1, 32'h0000_0000);
        queue_req(OP_DRAW, 2'd0, 32'h0);
        queue_req(OP_RESEED, 2'd2, 32'hFFFF_FFFF);
        queue_req(OP_DRAW, 2'd2, 32'hFFFF_FFFF);
        queue_req(OP_RESEED, 2'd3, seed_leading_to(32'h0000_0000));
        queue_req(OP_DRAW, 2'd2, 32'h0);
        wait_idle();

        // Random phases, each with a fresh set of ratios (kept to moderate means)
        for (int phase = 0; phase < PHASES; phase++)
        begin
            for (int idx = 0; idx < REG_COUNT; idx++)
                write_ratio(idx, pick_ratio());
            settings++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mid-phase pause: the source waits until every draw is answered
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    wait_idle();
                queue_req(($urandom_range(99) < RESEED_PCT) ? OP_RESEED : OP_DRAW,
                          SEL_W'($urandom_range(3)), DATA_W'($urandom));
            end
            wait_idle();
        end

        $display("Ran %0d draws (%0d saturated) and %0d reseeds across %0d ratio settings,",
                 draws, saturations, reseeds, settings);
        $display("with random stalls on both streams and one long sink hold-off.");
        if (mismatches == 0 && expected_variates.size() == 0)
            $display("geometric_random_variate_generator: match");
        else
            $display("geometric_random_variate_generator: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/grvg_pkg.sv
hdl/grvg_mul.sv
hdl/grvg_regs.sv
hdl/geometric_random_variate_generator.sv
dv/testbench.sv
